>>> rtl/packed_bitfield_read_write_unit_assert.svh
// Assertion macros for the packed bit-field read/write unit.
// Included by the top level; has no dependencies of its own.
`ifndef PACKED_BITFIELD_READ_WRITE_UNIT_ASSERT_SVH
`define PACKED_BITFIELD_READ_WRITE_UNIT_ASSERT_SVH
`ifndef SYNTH
// The consequent holds in the same cycle as the antecedent.
`define PBRW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// The consequent holds in the cycle after the antecedent.
`define PBRW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PBRW_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PBRW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/pbrw_pkg.sv
// Package for the packed bit-field read/write unit.
// Holds memory geometry constants, derived widths and the control state type.
`timescale 1ns / 1ps

package pbrw_pkg;

	localparam int WORD_BITS      = 64;
	localparam int MEM_WORDS      = 1024;
	localparam int MAX_FIELD_BITS = 64;

	localparam int ADDR_W  = 16;
	localparam int CNT_W   = 7;
	localparam int VAL_W   = 64;
	localparam int OFF_W   = $clog2(WORD_BITS);
	localparam int WIDX_W  = ADDR_W - OFF_W;
	localparam int SUM_W   = ADDR_W + 1;
	localparam int TOTAL_BITS  = WORD_BITS * MEM_WORDS;
	localparam int BANK_WORDS  = (MEM_WORDS + 1) / 2;
	localparam int ROW_W       = $clog2(BANK_WORDS);

	// Operation codes.
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Control states: clearing pass after reset, then normal operation.
	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} pbrw_state_t;

endpackage

>>> rtl/pbrw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; used for both word banks of the packed bit-field unit.
`timescale 1ns / 1ps

module pbrw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/packed_bitfield_read_write_unit.sv
// Top level of the packed bit-field read/write unit.
// Depends on pbrw_pkg, pbrw_ram and packed_bitfield_read_write_unit_assert.svh.
`timescale 1ns / 1ps

// Usage:
// A command transfer happens at a rising clock edge with start high and busy low.
// The command carries op (read or write), bit_address, bit_count and write_value.
// A read returns bit_count bits starting at bit_address, right-aligned and zero
// extended; a write replaces those bits with the low bits of write_value.
// Counts above 64 are treated as 64; a count of zero does nothing.
// A field reaching past the last memory bit sets out_of_range, reads zero and
// leaves the memory untouched.
// Each command gives exactly one result, shown on read_value and out_of_range for
// one cycle while done is high, after passing the stage 1 and result registers.
// The receiver cannot stall; a result must be taken in its done cycle.
// A new command is not taken while the last is in stage 1. Memory words live in two
// banks (even and odd words), so both words of a straddling field are read together
// and written back in the next cycle; busy covers that read-modify-write.
// After reset a clearing pass zeroes both banks, one row of each per cycle, until
// every row is cleared; busy stays high until it ends.

module packed_bitfield_read_write_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         op,
	input  logic [pbrw_pkg::ADDR_W-1:0]  bit_address,
	input  logic [pbrw_pkg::CNT_W-1:0]   bit_count,
	input  logic [pbrw_pkg::VAL_W-1:0]   write_value,
	output logic                         done,
	output logic [pbrw_pkg::VAL_W-1:0]   read_value,
	output logic                         out_of_range
);

	import pbrw_pkg::*;

	`include "packed_bitfield_read_write_unit_assert.svh"

	pbrw_state_t state_q, state_d;
	logic [ROW_W-1:0] clr_q, clr_d;
	logic             clearing;

	logic accept;

	// Command decode signals.
	logic [CNT_W-1:0]  cnt_sat;
	logic [SUM_W-1:0]  end_bit;
	logic              oor;
	logic [WIDX_W-1:0] widx;
	logic [WIDX_W:0]   widx_next;
	logic [WIDX_W:0]   even_idx;
	logic [WIDX_W:0]   odd_idx;
	logic [OFF_W:0]    off_plus;
	logic [CNT_W:0]    span_sum;
	logic [VAL_W-1:0]  field_mask;

	// Stage 1 registers: the command while the banks are read.
	logic                 v_s1;
	logic                 op_s1;
	logic                 oor_s1;
	logic                 span_s1;
	logic                 odd_s1;
	logic [OFF_W-1:0]     off_s1;
	logic [ROW_W-1:0]     even_row_s1;
	logic [ROW_W-1:0]     odd_row_s1;
	logic [VAL_W-1:0]     mask_s1;
	logic [VAL_W-1:0]     val_s1;

	// Bank ports.
	logic [WORD_BITS-1:0] even_rd, odd_rd;
	logic                 even_we, odd_we;
	logic [ROW_W-1:0]     even_waddr, odd_waddr;
	logic [WORD_BITS-1:0] even_wdata, odd_wdata;

	// Read-modify-write datapath.
	logic [WORD_BITS-1:0]   lo_word, hi_word;
	logic [2*WORD_BITS-1:0] pair, pair_new, pair_shr, mask_shl, val_shl;
	logic                   wr_go;

	// Result registers.
	logic                 done_q;
	logic [VAL_W-1:0]     read_value_q;
	logic                 oor_q;

	assign busy   = clearing || v_s1;
	assign accept = start && !busy;

	// Control state register and clear counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
		end
	end

	// Next state: sweep every bank row once, then run.
	always_comb begin
		state_d  = state_q;
		clr_d    = clr_q;
		clearing = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				clearing = 1'b1;
				clr_d    = clr_q + 1'b1;
				if (clr_q == ROW_W'(BANK_WORDS - 1)) begin
					state_d = ST_RUN;
					clr_d   = '0;
				end
			end
			ST_RUN: begin
				clearing = 1'b0;
			end
			default: begin
				state_d = ST_CLEAR;
				clr_d   = '0;
			end
		endcase
	end

	// Decode the command: saturate the count, check the range, locate both words.
	always_comb begin
		cnt_sat   = (bit_count > CNT_W'(MAX_FIELD_BITS)) ? CNT_W'(MAX_FIELD_BITS) : bit_count;
		end_bit   = SUM_W'(bit_address) + SUM_W'(cnt_sat);
		oor       = (end_bit > SUM_W'(TOTAL_BITS));
		widx      = bit_address[ADDR_W-1:OFF_W];
		widx_next = {1'b0, widx} + 1'b1;
		even_idx  = widx[0] ? widx_next : {1'b0, widx};
		odd_idx   = widx[0] ? {1'b0, widx} : widx_next;
		off_plus  = {1'b0, bit_address[OFF_W-1:0]};
		span_sum  = CNT_W'(off_plus) + {1'b0, cnt_sat};
		if (cnt_sat == '0) begin
			field_mask = '0;
		end else begin
			field_mask = {VAL_W{1'b1}} >> (CNT_W'(VAL_W) - cnt_sat);
		end
	end

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= op;
			oor_s1      <= oor;
			span_s1     <= (span_sum > (CNT_W + 1)'(WORD_BITS));
			odd_s1      <= widx[0];
			off_s1      <= bit_address[OFF_W-1:0];
			even_row_s1 <= even_idx[ROW_W:1];
			odd_row_s1  <= odd_idx[ROW_W:1];
			mask_s1     <= field_mask;
			val_s1      <= write_value & field_mask;
		end
	end

	// Put the two words in address order and build the shifted field masks.
	always_comb begin
		lo_word  = odd_s1 ? odd_rd : even_rd;
		hi_word  = odd_s1 ? even_rd : odd_rd;
		pair     = {hi_word, lo_word};
		pair_shr = pair >> off_s1;
		mask_shl = {{(2*WORD_BITS-VAL_W){1'b0}}, mask_s1} << off_s1;
		val_shl  = {{(2*WORD_BITS-VAL_W){1'b0}}, val_s1} << off_s1;
		pair_new = (pair & ~mask_shl) | val_shl;
		wr_go    = v_s1 && (op_s1 == OP_WRITE) && !oor_s1 && (mask_s1 != '0);
	end

	// Bank write ports: zeros during the clearing pass, else the merged words.
	always_comb begin
		if (clearing) begin
			even_we    = 1'b1;
			odd_we     = 1'b1;
			even_waddr = clr_q;
			odd_waddr  = clr_q;
			even_wdata = '0;
			odd_wdata  = '0;
		end else begin
			even_we    = wr_go && (!odd_s1 || span_s1);
			odd_we     = wr_go && (odd_s1 || span_s1);
			even_waddr = even_row_s1;
			odd_waddr  = odd_row_s1;
			even_wdata = odd_s1 ? pair_new[2*WORD_BITS-1:WORD_BITS]
			                    : pair_new[WORD_BITS-1:0];
			odd_wdata  = odd_s1 ? pair_new[WORD_BITS-1:0]
			                    : pair_new[2*WORD_BITS-1:WORD_BITS];
		end
	end

	pbrw_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (BANK_WORDS)
	) u_even_bank (
		.clk   (clk),
		.we    (even_we),
		.waddr (even_waddr),
		.wdata (even_wdata),
		.re    (accept),
		.raddr (even_idx[ROW_W:1]),
		.rdata (even_rd)
	);

	pbrw_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (BANK_WORDS)
	) u_odd_bank (
		.clk   (clk),
		.we    (odd_we),
		.waddr (odd_waddr),
		.wdata (odd_wdata),
		.re    (accept),
		.raddr (odd_idx[ROW_W:1]),
		.rdata (odd_rd)
	);

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s1;
		end
	end

	// Result payload: extracted field for in-range reads, zero otherwise.
	always_ff @(posedge clk) begin
		if (v_s1) begin
			oor_q <= oor_s1;
			if ((op_s1 == OP_READ) && !oor_s1) begin
				read_value_q <= pair_shr[VAL_W-1:0] & mask_s1;
			end else begin
				read_value_q <= '0;
			end
		end
	end

	assign done         = done_q;
	assign read_value   = read_value_q;
	assign out_of_range = oor_q;

	// Every command transfer fills stage 1 and then yields a result.
	`PBRW_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, v_s1 && busy)
	`PBRW_ASSERT_NEXT(a_s1_done, clk, arst_n, v_s1, done)
	// A flagged access always reports a zero field.
	`PBRW_ASSERT_SAME(a_oor_zero, clk, arst_n, done && out_of_range, read_value == '0)
	// No command is taken while the clearing pass runs.
	`PBRW_ASSERT_SAME(a_clear_idle, clk, arst_n, clearing, !accept && !v_s1)

endmodule

>>> verif/tb_packed_bitfield_read_write_unit.sv
// Testbench for the packed bit-field read/write unit: directed and random field transfers,
// each checked against a bit-level shadow of the packed memory.
// Depends on pbrw_pkg and the packed_bitfield_read_write_unit top level.
`timescale 1ns / 1ps

module tb_packed_bitfield_read_write_unit;
	import pbrw_pkg::*;

	localparam int RANDOM_CMDS = 1900;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_GAP     = 12;
	localparam int REPORT_MAX  = 10;

	typedef struct {
		logic               op;
		logic [ADDR_W-1:0]  addr;
		logic [CNT_W-1:0]   cnt;
		logic [VAL_W-1:0]   value;
	} field_cmd_t;

	typedef struct {
		field_cmd_t         cmd;
		logic [VAL_W-1:0]   read_value;
		logic               out_of_range;
	} field_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               op = OP_READ;
	logic [ADDR_W-1:0]  bit_address = '0;
	logic [CNT_W-1:0]   bit_count = '0;
	logic [VAL_W-1:0]   write_value = '0;
	logic               done;
	logic [VAL_W-1:0]   read_value;
	logic               out_of_range;

	// Shadow copy of the packed memory, cleared like the block after reset.
	logic [WORD_BITS-1:0] shadow_words [MEM_WORDS];

	field_cmd_t    pending_cmds[$];
	field_result_t expected_results[$];
	field_cmd_t    issued_cmd;
	int            gap_left = 0;
	bit            burst_mode = 1'b0;
	int            error_count = 0;
	int            cycle_count = 0;

	packed_bitfield_read_write_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.bit_address  (bit_address),
		.bit_count    (bit_count),
		.write_value  (write_value),
		.done         (done),
		.read_value   (read_value),
		.out_of_range (out_of_range)
	);

	always #6 clk = ~clk;

	// Applies one field transfer to the shadow memory and returns what the block should answer.
	function automatic field_result_t access_field(field_cmd_t c);
		field_result_t r;
		int unsigned   n;
		int unsigned   pos;
		r.cmd = c;
		r.read_value = '0;
		r.out_of_range = 1'b0;
		n = (c.cnt > MAX_FIELD_BITS) ? MAX_FIELD_BITS : c.cnt;
		if (int'(c.addr) + n > TOTAL_BITS) begin
			r.out_of_range = 1'b1;
		end else begin
			for (int unsigned i = 0; i < n; i++) begin
				pos = c.addr + i;
				if (c.op == OP_READ)
					r.read_value[i] = shadow_words[pos / WORD_BITS][pos % WORD_BITS];
				else
					shadow_words[pos / WORD_BITS][pos % WORD_BITS] = c.value[i];
			end
		end
		return r;
	endfunction

	function automatic void queue_cmd(logic o, int unsigned a, int unsigned n,
			logic [VAL_W-1:0] v);
		field_cmd_t c;
		c.op = o;
		c.addr = a[ADDR_W-1:0];
		c.cnt = n[CNT_W-1:0];
		c.value = v;
		pending_cmds.push_back(c);
	endfunction

	function automatic logic [VAL_W-1:0] random_word();
		return {$urandom, $urandom};
	endfunction

	// Command driver: presents queued commands and records each transfer for prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			op <= OP_READ;
			bit_address <= '0;
			bit_count <= '0;
			write_value <= '0;
			gap_left <= 0;
		end else begin
			if (start && !busy)
				expected_results.push_back(access_field(issued_cmd));
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					issued_cmd = pending_cmds.pop_front();
					op <= issued_cmd.op;
					bit_address <= issued_cmd.addr;
					bit_count <= issued_cmd.cnt;
					write_value <= issued_cmd.value;
					start <= 1'b1;
					// Occasionally switch between back-to-back bursts and random gaps.
					if ($urandom_range(0, 63) == 0)
						burst_mode = ~burst_mode;
					gap_left <= burst_mode ? 0 : $urandom_range(0, MAX_GAP);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Result monitor: every done cycle is compared with the oldest expectation.
	always @(posedge clk) begin
		field_result_t exp_r;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				error_count <= error_count + 1;
				if (error_count < REPORT_MAX)
					$display("unexpected result: read_value %h out_of_range %b",
						read_value, out_of_range);
			end else begin
				exp_r = expected_results.pop_front();
				if (read_value !== exp_r.read_value || out_of_range !== exp_r.out_of_range) begin
					error_count <= error_count + 1;
					if (error_count < REPORT_MAX)
						$display("mismatch: op %b addr %0d cnt %0d: read_value exp %h got %h, out_of_range exp %b got %b",
							exp_r.cmd.op, exp_r.cmd.addr, exp_r.cmd.cnt,
							exp_r.read_value, read_value, exp_r.out_of_range, out_of_range);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** packed_bitfield_read_write_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		int unsigned hot_word;
		int unsigned sel;
		int unsigned a;
		int unsigned n;
		for (int i = 0; i < MEM_WORDS; i++)
			shadow_words[i] = '0;

		// Directed: cleared memory, full words, zero and oversized counts.
		queue_cmd(OP_READ, 0, 64, '0);
		queue_cmd(OP_WRITE, 0, 64, '1);
		queue_cmd(OP_READ, 0, 64, '0);
		queue_cmd(OP_WRITE, 100, 0, '1);
		queue_cmd(OP_READ, 96, 16, '0);
		queue_cmd(OP_READ, 5, 0, '0);
		queue_cmd(OP_WRITE, 64 * 5 + 13, 127, 64'hA5C3_0FF0_1234_9876);
		queue_cmd(OP_READ, 64 * 5 + 13, 100, '0);
		queue_cmd(OP_READ, 64 * 5, 64, '0);
		// Fields that straddle a word boundary.
		queue_cmd(OP_WRITE, 60, 8, 64'hFFFF_FFFF_FFFF_FF5A);
		queue_cmd(OP_READ, 56, 16, '0);
		queue_cmd(OP_WRITE, 64 * 9 + 1, 64, 64'h8000_0000_0000_0001);
		queue_cmd(OP_READ, 64 * 9, 64, '0);
		queue_cmd(OP_READ, 64 * 10, 64, '0);
		// Short write inside one word keeps the neighbors.
		queue_cmd(OP_WRITE, 130, 3, '0);
		queue_cmd(OP_READ, 128, 64, '0);
		// Last bits of memory and accesses past its end.
		queue_cmd(OP_WRITE, TOTAL_BITS - 1, 1, 64'h1);
		queue_cmd(OP_WRITE, TOTAL_BITS - 64, 63, '1);
		queue_cmd(OP_READ, TOTAL_BITS - 64, 64, '0);
		queue_cmd(OP_READ, TOTAL_BITS - 1, 2, '0);
		queue_cmd(OP_WRITE, TOTAL_BITS - 63, 64, '0);
		queue_cmd(OP_WRITE, TOTAL_BITS - 1, 127, '0);
		queue_cmd(OP_READ, TOTAL_BITS - 1, 0, '0);
		queue_cmd(OP_READ, TOTAL_BITS - 64, 64, '0);

		// Random: mostly traffic around a moving hot window so reads see written data.
		hot_word = 0;
		for (int k = 0; k < RANDOM_CMDS; k++) begin
			if (k % 100 == 0)
				hot_word = $urandom_range(0, MEM_WORDS - 5);
			sel = $urandom_range(0, 99);
			if (sel < 65)
				a = hot_word * WORD_BITS + $urandom_range(0, 4 * WORD_BITS - 1);
			else if (sel < 85)
				a = $urandom_range(0, TOTAL_BITS - 1);
			else
				a = TOTAL_BITS - $urandom_range(1, 140);
			sel = $urandom_range(0, 99);
			if (sel < 5)
				n = 0;
			else if (sel < 15)
				n = $urandom_range(MAX_FIELD_BITS + 1, 127);
			else if (sel < 25)
				n = ($urandom_range(0, 1) == 0) ? 1 : $urandom_range(63, 64);
			else
				n = $urandom_range(1, MAX_FIELD_BITS);
			queue_cmd($urandom_range(0, 1) ? OP_WRITE : OP_READ, a, n, random_word());
		end

		// Single reset at the start; released away from the rising edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every command to be taken, then for all results and a few spare cycles.
		while (pending_cmds.size() != 0 || start)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("** packed_bitfield_read_write_unit: PASSED **");
		else
			$display("** packed_bitfield_read_write_unit: FAILED **");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/pbrw_pkg.sv
rtl/pbrw_ram.sv
rtl/packed_bitfield_read_write_unit.sv
verif/tb_packed_bitfield_read_write_unit.sv
